// File: design/three_axis_lockin_demodulator_assert.svh
// ---------------------------------------------------------------------------
// three-axis lock-in demodulator assertion macros
// concurrent checks clocked on i_clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef THREE_AXIS_LOCKIN_DEMODULATOR_ASSERT_SVH
`define THREE_AXIS_LOCKIN_DEMODULATOR_ASSERT_SVH

// same-cycle implication
`define TALD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tald check failed");

// next-cycle implication
`define TALD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tald check failed");

`endif

// File: design/tald_pkg.sv
// ---------------------------------------------------------------------------
// tald_pkg
// shared types and constants of the three-axis lock-in demodulator
// ---------------------------------------------------------------------------
package tald_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int STEP_W    = 31;
    localparam int GAIN_W    = 16;
    localparam int AMP_W     = 31;
    localparam int STATE_W   = 32;
    localparam int SINE_W    = 16;
    localparam int ROM_W     = 15;
    localparam int ROOT_W    = 63;
    localparam int ROOT_CYC  = 16;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd655;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 8'd1;

    typedef struct packed {
        logic mix;
        logic gain;
        logic upd;
        logic sqr;
        logic sum;
        logic root;
    } t_lane_ctl;

endpackage

// File: design/tald_rom.sv
// ---------------------------------------------------------------------------
// tald_rom
// quarter-wave sine table, two registered read ports
// ---------------------------------------------------------------------------
module tald_rom
    import tald_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int A_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic [A_W-1:0]   i_addr_a,
    input  logic [A_W-1:0]   i_addr_b,
    output logic [ROM_W-1:0] o_data_a,
    output logic [ROM_W-1:0] o_data_b
);

    typedef logic [ROM_W-1:0] t_rom_arr [0:SINE_TABLE_DEPTH];

    localparam longint unsigned Q30One   = 64'd1073741824;
    localparam longint unsigned HalfPi   = 64'd1686629713;

    // taylor series of sin in q30, evaluated at elaboration
    function automatic logic [ROM_W-1:0] quarter_entry(longint unsigned k);
        longint unsigned x, x2, t, s, r;
        x  = k * HalfPi / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30One;
        t  = Q30One - ((x2 * t) >> 30) / 156;
        t  = Q30One - ((x2 * t) >> 30) / 110;
        t  = Q30One - ((x2 * t) >> 30) / 72;
        t  = Q30One - ((x2 * t) >> 30) / 42;
        t  = Q30One - ((x2 * t) >> 30) / 20;
        t  = Q30One - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[ROM_W-1:0];
    endfunction

    function automatic t_rom_arr build_rom();
        t_rom_arr a;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            a[k] = quarter_entry(64'(k));
        end
        return a;
    endfunction

    localparam t_rom_arr RomInit = build_rom();

    logic [ROM_W-1:0] r_data_a;
    logic [ROM_W-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        r_data_a <= RomInit[i_addr_a];
        r_data_b <= RomInit[i_addr_b];
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// File: design/tald_lane.sv
// ---------------------------------------------------------------------------
// tald_lane
// one axis: i/q mixing, one-pole low-pass pair, magnitude square root
// ---------------------------------------------------------------------------
module tald_lane
    import tald_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SINE_W-1:0]      i_sin,
    input  logic signed [SINE_W-1:0]      i_cos,
    input  logic        [GAIN_W-1:0]      i_gain,
    output logic        [AMP_W-1:0]       o_amp
);

    localparam int PROD_W = SAMPLE_BITS + SINE_W;
    localparam int SH_R   = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam int SH_L   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int GP_W   = STATE_W + 1 + GAIN_W + 1;
    localparam int STEP_SW = GP_W - 16;
    localparam int NEXT_W = STEP_SW + 1;
    localparam int SQ_W   = 2 * (STATE_W - 1);
    localparam logic signed [NEXT_W-1:0] Limit = NEXT_W'(64'sd1073741824);

    typedef struct packed {
        logic [ROOT_W-1:0] v;
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] b;
    } t_root;

    logic signed [STATE_W-1:0] r_mi, r_mq;
    logic signed [GP_W-1:0]    r_pi, r_pq;
    logic signed [STATE_W-1:0] r_fi, r_fq;
    logic [SQ_W-1:0]           r_si, r_sq;
    t_root                     r_rt;

    logic signed [STATE_W-1:0] n_mi, n_mq, n_fi, n_fq;
    t_root                     n_rt;

    function automatic logic signed [STATE_W-1:0] to_q30(logic signed [PROD_W-1:0] p);
        logic signed [STATE_W-1:0] m;
        m = STATE_W'(p >>> SH_R);
        return m <<< SH_L;
    endfunction

    function automatic logic signed [GP_W-1:0] gain_mul(logic signed [STATE_W-1:0] m,
                                                         logic signed [STATE_W-1:0] f);
        logic signed [STATE_W:0]  d;
        logic signed [GAIN_W:0]   g;
        d = (STATE_W+1)'(m) - (STATE_W+1)'(f);
        g = signed'({1'b0, i_gain});
        return GP_W'(d) * GP_W'(g);
    endfunction

    // round to nearest, ties upward, then clamp to +-1.0 in q2.30
    function automatic logic signed [STATE_W-1:0] filt_upd(logic signed [STATE_W-1:0] f,
                                                           logic signed [GP_W-1:0] p);
        logic signed [GP_W-1:0]   pr;
        logic signed [NEXT_W-1:0] n;
        pr = p + GP_W'(32768);
        n  = NEXT_W'(f) + NEXT_W'(signed'(pr[GP_W-1:16]));
        if (n > Limit) begin
            n = Limit;
        end else if (n < -Limit) begin
            n = -Limit;
        end
        return STATE_W'(n);
    endfunction

    function automatic logic [STATE_W-2:0] mag(logic signed [STATE_W-1:0] f);
        logic signed [STATE_W-1:0] a;
        a = f[STATE_W-1] ? -f : f;
        return a[STATE_W-2:0];
    endfunction

    function automatic t_root root_step(t_root s);
        t_root           o;
        logic [ROOT_W:0] t;
        t = {1'b0, s.r} + {1'b0, s.b};
        if ({1'b0, s.v} >= t) begin
            o.v = s.v - t[ROOT_W-1:0];
            o.r = (s.r >> 1) + s.b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        o.b = s.b >> 2;
        return o;
    endfunction

    always_comb begin
        n_mi = to_q30(PROD_W'(i_sample) * PROD_W'(i_cos));
        n_mq = to_q30(PROD_W'(i_sample) * PROD_W'(i_sin));
        n_fi = filt_upd(r_fi, r_pi);
        n_fq = filt_upd(r_fq, r_pq);
        n_rt = root_step(root_step(r_rt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi <= '0;
            r_fq <= '0;
        end else if (i_ctl.upd) begin
            r_fi <= n_fi;
            r_fq <= n_fq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mix) begin
            r_mi <= n_mi;
            r_mq <= n_mq;
        end
        if (i_ctl.gain) begin
            r_pi <= gain_mul(r_mi, r_fi);
            r_pq <= gain_mul(r_mq, r_fq);
        end
        if (i_ctl.sqr) begin
            r_si <= SQ_W'(mag(r_fi)) * SQ_W'(mag(r_fi));
            r_sq <= SQ_W'(mag(r_fq)) * SQ_W'(mag(r_fq));
        end
        if (i_ctl.sum) begin
            r_rt.v <= ROOT_W'(r_si) + ROOT_W'(r_sq);
            r_rt.r <= '0;
            r_rt.b <= ROOT_W'(1) << (ROOT_W - 1);
        end else if (i_ctl.root) begin
            r_rt <= n_rt;
        end
    end

    assign o_amp = r_rt.r[AMP_W-1:0];

endmodule

// File: design/three_axis_lockin_demodulator.sv
// ---------------------------------------------------------------------------
// three_axis_lockin_demodulator
// three-axis lock-in i/q demodulator with per-axis amplitude output
// ---------------------------------------------------------------------------
// One word of X, Y, Z samples goes in and one word of three amplitudes comes
// out. A phase accumulator picks sine and cosine from a quarter-wave table;
// three lanes, one per axis, mix, low-pass and take sqrt(I^2 + Q^2), and the
// output register merges the three lane results into one word. Items are
// handled one at a time through the address, table, mix, gain, update,
// square, sum, root and done states; the square root resolves two result
// bits a cycle. A new word is taken while the previous result still waits.
// The first item after reset uses phase zero; the phase advances by
// phase_step for every accepted word. Configuration is taken at any time
// (o_cfg_ready is always high) and must only be written while idle.
// ---------------------------------------------------------------------------
module three_axis_lockin_demodulator
    import tald_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_z_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic        [AMP_W-1:0]       o_amp_x,
    output logic        [AMP_W-1:0]       o_amp_y,
    output logic        [AMP_W-1:0]       o_amp_z,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int FULL  = 4 * SINE_TABLE_DEPTH;
    localparam int IDX_W = $clog2(FULL);
    localparam int A_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MUL_W = PHASE_BITS + IDX_W + 1;
    localparam logic [IDX_W:0] D1 = (IDX_W+1)'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W:0] D2 = (IDX_W+1)'(2 * SINE_TABLE_DEPTH);
    localparam logic [IDX_W:0] D3 = (IDX_W+1)'(3 * SINE_TABLE_DEPTH);
    localparam logic [IDX_W:0] D4 = (IDX_W+1)'(FULL);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADDR = 4'd1;
    localparam logic [3:0] S_ROM  = 4'd2;
    localparam logic [3:0] S_MIX  = 4'd3;
    localparam logic [3:0] S_GAIN = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_SQR  = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_ROOT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    typedef struct packed {
        logic [A_W-1:0] addr;
        logic           neg;
    } t_rom_sel;

    logic [3:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [STEP_W-1:0]             r_step;
    logic [GAIN_W-1:0]             r_gain;
    logic [IDX_W-1:0]              r_idx;
    t_rom_sel                      r_sel_s, r_sel_c;
    logic signed [SAMPLE_BITS-1:0] r_xs, r_ys, r_zs;
    logic                          r_out_valid;
    logic [AMP_W-1:0]              r_amp_x, r_amp_y, r_amp_z;

    logic                  in_acc;
    logic                  out_load;
    logic [MUL_W-1:0]      idx_prod;
    logic [IDX_W:0]        cidx_sum;
    logic [IDX_W-1:0]      cidx;
    logic [ROM_W-1:0]      rom_s, rom_c;
    logic signed [SINE_W-1:0] sin_v, cos_v;
    t_lane_ctl             lane_ctl;
    logic [AMP_W-1:0]      lane_amp_x, lane_amp_y, lane_amp_z;

    // full-wave index to table address and sign by quadrant
    function automatic t_rom_sel map_idx(logic [IDX_W-1:0] idx);
        t_rom_sel       s;
        logic [IDX_W:0] w;
        logic [IDX_W:0] a;
        w = {1'b0, idx};
        if (w < D1) begin
            a = w;
            s.neg = 1'b0;
        end else if (w < D2) begin
            a = D2 - w;
            s.neg = 1'b0;
        end else if (w < D3) begin
            a = w - D2;
            s.neg = 1'b1;
        end else begin
            a = D4 - w;
            s.neg = 1'b1;
        end
        s.addr = a[A_W-1:0];
        return s;
    endfunction

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // index = phase * 4 * depth / 2^phase_bits
    assign idx_prod = MUL_W'(r_phase) * MUL_W'(FULL);
    assign cidx_sum = {1'b0, r_idx} + D1;
    assign cidx     = (cidx_sum >= D4) ? IDX_W'(cidx_sum - D4) : cidx_sum[IDX_W-1:0];

    // signed q1.15 sine and cosine from the table words
    assign sin_v = r_sel_s.neg ? -signed'({1'b0, rom_s}) : signed'({1'b0, rom_s});
    assign cos_v = r_sel_c.neg ? -signed'({1'b0, rom_c}) : signed'({1'b0, rom_c});

    always_comb begin
        lane_ctl      = '0;
        lane_ctl.mix  = (r_state == S_MIX);
        lane_ctl.gain = (r_state == S_GAIN);
        lane_ctl.upd  = (r_state == S_UPD);
        lane_ctl.sqr  = (r_state == S_SQR);
        lane_ctl.sum  = (r_state == S_SUM);
        lane_ctl.root = (r_state == S_ROOT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_ADDR;
            S_ADDR: n_state = S_ROM;
            S_ROM:  n_state = S_MIX;
            S_MIX:  n_state = S_GAIN;
            S_GAIN: n_state = S_UPD;
            S_UPD:  n_state = S_SQR;
            S_SQR:  n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: if (r_cnt == CNT_W'(ROOT_CYC - 1)) n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_gain      <= GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ROOT) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (in_acc) begin
                r_phase <= r_phase + PHASE_BITS'(r_step);
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_PHASE_STEP) begin
                    r_step <= i_cfg_data[STEP_W-1:0];
                end else if (i_cfg_index == REG_FILTER_GAIN) begin
                    r_gain <= i_cfg_data[GAIN_W-1:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_xs  <= i_x_sample;
            r_ys  <= i_y_sample;
            r_zs  <= i_z_sample;
            r_idx <= idx_prod[PHASE_BITS +: IDX_W];
        end
        if (r_state == S_ADDR) begin
            r_sel_s <= map_idx(r_idx);
            r_sel_c <= map_idx(cidx);
        end
        // merge stage: the three lane results form one word
        if (out_load) begin
            r_amp_x <= lane_amp_x;
            r_amp_y <= lane_amp_y;
            r_amp_z <= lane_amp_z;
        end
    end

    tald_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .A_W              (A_W)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr_a (r_sel_s.addr),
        .i_addr_b (r_sel_c.addr),
        .o_data_a (rom_s),
        .o_data_b (rom_c)
    );

    tald_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl), .i_sample (r_xs),
        .i_sin (sin_v), .i_cos (cos_v), .i_gain (r_gain), .o_amp (lane_amp_x)
    );

    tald_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl), .i_sample (r_ys),
        .i_sin (sin_v), .i_cos (cos_v), .i_gain (r_gain), .o_amp (lane_amp_y)
    );

    tald_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl), .i_sample (r_zs),
        .i_sin (sin_v), .i_cos (cos_v), .i_gain (r_gain), .o_amp (lane_amp_z)
    );

    assign o_out_valid = r_out_valid;
    assign o_amp_x     = r_amp_x;
    assign o_amp_y     = r_amp_y;
    assign o_amp_z     = r_amp_z;

`include "three_axis_lockin_demodulator_assert.svh"

    // one word in flight at a time
    `TALD_ASSERT_NEXT(a_one_in_flight, in_acc, !o_in_ready)
    // phase advances by exactly one step per accepted word
    `TALD_ASSERT_NEXT(a_phase_step, in_acc, r_phase == $past(r_phase + PHASE_BITS'(r_step)))
    // a finished result never overwrites one still waiting
    `TALD_ASSERT_NOW(a_no_overwrite, out_load && r_out_valid, i_out_ready)

endmodule

// File: tb/tb_three_axis_lockin_demodulator.sv
// ---------------------------------------------------------------------------
// tb_three_axis_lockin_demodulator
// self-checking bench for the three-axis lock-in demodulator
// ---------------------------------------------------------------------------
// Samples are driven through the input channel with random gaps. The output
// channel stalls at random. A local model of the phase accumulator, the
// quarter-wave table, the filters and the square root predicts every
// amplitude word. Each received word is compared field by field with the
// oldest prediction. Register writes happen only while the block is idle.
// ---------------------------------------------------------------------------
module tb_three_axis_lockin_demodulator;
    import tald_pkg::*;

    localparam int                   HALF_CYCLE   = 4;
    localparam int                   QUARTER      = SINE_DEPTH_DEF;
    localparam int                   IDLE_LIMIT   = 3000;
    localparam int                   SETTLE_CYC   = 60;
    localparam int                   REPORT_MAX   = 10;
    localparam longint unsigned      Q30_ONE      = 64'd1073741824;
    localparam longint unsigned      HALF_PI_Q30  = 64'd1686629713;
    localparam longint               STATE_LIMIT  = 64'sd1073741824;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 8'd7;

    typedef struct {
        logic [AMP_W-1:0] amp_x;
        logic [AMP_W-1:0] amp_y;
        logic [AMP_W-1:0] amp_z;
    } t_amp_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [15:0]         i_x_sample;
    logic signed [15:0]         i_y_sample;
    logic signed [15:0]         i_z_sample;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [AMP_W-1:0]           o_amp_x;
    logic [AMP_W-1:0]           o_amp_y;
    logic [AMP_W-1:0]           o_amp_z;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DAT_W-1:0]       i_cfg_data;

    three_axis_lockin_demodulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_sample  (i_x_sample),
        .i_y_sample  (i_y_sample),
        .i_z_sample  (i_z_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_amp_x     (o_amp_x),
        .o_amp_y     (o_amp_y),
        .o_amp_z     (o_amp_z),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // demodulator model state
    logic [STEP_W-1:0]  tune_word;
    logic [GAIN_W-1:0]  alpha;
    logic [31:0]        phase_acc;
    int                 i_state [3];
    int                 q_state [3];
    int                 quarter_table [0:QUARTER];

    t_amp_word          amp_queue [$];
    int                 mismatches;
    int                 idle_cycles;
    bit                 stall_free;
    int                 out_hold;

    always begin
        i_clk = 1'b1;
        #HALF_CYCLE;
        i_clk = 1'b0;
        #HALF_CYCLE;
    end

    // quarter-wave entry from a fixed-point taylor series
    function automatic int quarter_entry(int k);
        longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t, s, r;
        x  = longint'(k) * HALF_PI_Q30 / QUARTER;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 0; n < 6; n++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / divs[n];
        end
        s = (x * t) >> 30;
        r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return int'(r);
    endfunction

    function automatic longint wave_value(int idx);
        int quad;
        int k;
        quad = (idx / QUARTER) & 3;
        k    = idx % QUARTER;
        case (quad)
            0: return quarter_table[k];
            1: return quarter_table[QUARTER - k];
            2: return -quarter_table[k];
            default: return -quarter_table[QUARTER - k];
        endcase
    endfunction

    // one-pole low-pass, round half up, clamped to +-1.0 in q2.30
    function automatic int lowpass(int f, longint m);
        longint d, st, n;
        d  = m - longint'(f);
        st = (d * longint'({1'b0, alpha}) + 64'sd32768) >>> 16;
        n  = longint'(f) + st;
        if (n > STATE_LIMIT) n = STATE_LIMIT;
        if (n < -STATE_LIMIT) n = -STATE_LIMIT;
        return int'(n);
    endfunction

    function automatic logic [AMP_W-1:0] magnitude(int iv, int qv);
        longint unsigned ia, qa, v, r, b;
        ia = (iv < 0) ? longint'(-longint'(iv)) : longint'(iv);
        qa = (qv < 0) ? longint'(-longint'(qv)) : longint'(qv);
        v  = ia * ia + qa * qa;
        r  = 0;
        b  = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[AMP_W-1:0];
    endfunction

    // mix, filter and measure one sample triple, then advance the phase
    task automatic demodulate(input logic signed [15:0] xs, input logic signed [15:0] ys,
                              input logic signed [15:0] zs);
        longint    sn, cs, smp;
        int        idx;
        t_amp_word w;
        logic [AMP_W-1:0] amps [3];
        idx = int'(phase_acc[31:20]);
        sn  = wave_value(idx);
        cs  = wave_value((idx + QUARTER) % (4 * QUARTER));
        for (int a = 0; a < 3; a++) begin
            smp = (a == 0) ? longint'(xs) : (a == 1) ? longint'(ys) : longint'(zs);
            i_state[a] = lowpass(i_state[a], smp * cs);
            q_state[a] = lowpass(q_state[a], smp * sn);
            amps[a] = magnitude(i_state[a], q_state[a]);
        end
        w.amp_x = amps[0];
        w.amp_y = amps[1];
        w.amp_z = amps[2];
        amp_queue.push_back(w);
        phase_acc = phase_acc + {1'b0, tune_word};
    endtask

    // output-side backpressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (stall_free) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            out_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // accepted samples feed the model, accepted words are checked
    always @(posedge i_clk) begin
        t_amp_word want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
                (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_in_valid && o_in_ready) begin
                demodulate(i_x_sample, i_y_sample, i_z_sample);
            end
            if (o_out_valid && i_out_ready) begin
                if (amp_queue.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected word x=%0d y=%0d z=%0d", o_amp_x, o_amp_y,
                                 o_amp_z);
                    end
                end else begin
                    want = amp_queue.pop_front();
                    if (want.amp_x !== o_amp_x || want.amp_y !== o_amp_y ||
                        want.amp_z !== o_amp_z) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_MAX) begin
                            $display("amplitude mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     want.amp_x, want.amp_y, want.amp_z,
                                     o_amp_x, o_amp_y, o_amp_z);
                        end
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one word onto the input channel; valid stays up if the next follows at once
    task automatic send_samples(input logic signed [15:0] xs, input logic signed [15:0] ys,
                                input logic signed [15:0] zs);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_x_sample <= xs;
        i_y_sample <= ys;
        i_z_sample <= zs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (stall_free) begin
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            gap = $urandom_range(10, 40);
        end else begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drain, let the pipeline settle, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (amp_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_PHASE_STEP) begin
            tune_word = val[STEP_W-1:0];
        end else if (idx == REG_FILTER_GAIN) begin
            alpha = val[GAIN_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // full-scale and zero samples on every quadrant boundary at default gain
    task automatic test_extremes();
        logic signed [15:0] ext [4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
        write_reg(REG_PHASE_STEP, 32'hC000_0000);   // upper bit masked, quarter turn
        for (int n = 0; n < 8; n++) begin
            send_samples(ext[n % 4], ext[(n + 1) % 4], ext[(n + 2) % 4]);
        end
    endtask

    // widest tuning word and fastest filter saturate the states
    task automatic test_fast_filter();
        write_reg(REG_FILTER_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'h7FFF_FFFF);
        for (int n = 0; n < 6; n++) begin
            send_samples(-16'sd32768, 16'sd32767, (n % 2) ? 16'sd32767 : -16'sd32768);
        end
    endtask

    // zero gain freezes the filters; spare index is ignored
    task automatic test_frozen_filter();
        write_reg(REG_FILTER_GAIN, 32'h0001_0000);
        write_reg(REG_SPARE, 32'h0000_1234);
        for (int n = 0; n < 4; n++) begin
            send_samples(16'sd12345, -16'sd32768, 16'sd32767);
        end
        write_reg(REG_FILTER_GAIN, 32'd1);
        write_reg(REG_PHASE_STEP, 32'd0);
        for (int n = 0; n < 4; n++) begin
            send_samples(16'sd32767, 16'sd32767, -16'sd32768);
        end
    endtask

    // random settings, tone-like and full-range samples, with and without idling
    task automatic test_random(int items);
        logic signed [15:0] xs, ys, zs;
        int                 left;
        int                 chunk;
        left = items;
        while (left > 0) begin
            chunk = (left < 150) ? left : 150;
            write_reg(REG_PHASE_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 27));
            write_reg(REG_FILTER_GAIN, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 65535));
            stall_free = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < chunk; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    xs = 16'($urandom);
                    ys = 16'($urandom);
                    zs = 16'($urandom);
                end else begin
                    // sinusoid-like amplitude pattern with random sign and jitter
                    xs = 16'(wave_value((n * 64) % (4 * QUARTER))
                             + $signed($urandom_range(0, 255)) - 128);
                    ys = -xs;
                    zs = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                send_samples(xs, ys, zs);
            end
            stall_free = 1'b0;
            left = left - chunk;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_x_sample  = '0;
        i_y_sample  = '0;
        i_z_sample  = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tune_word   = '0;
        alpha       = GAIN_RESET;
        phase_acc   = '0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_free  = 1'b0;
        out_hold    = 0;
        for (int a = 0; a < 3; a++) begin
            i_state[a] = 0;
            q_state[a] = 0;
        end
        for (int k = 0; k <= QUARTER; k++) begin
            quarter_table[k] = quarter_entry(k);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: phase held at zero, gain about 0.01
        for (int n = 0; n < 3; n++) begin
            send_samples(16'sd32767, -16'sd32768, 16'sd1);
        end
        test_extremes();
        test_fast_filter();
        test_frozen_filter();
        test_random(1330);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (amp_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && amp_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
